FILE: design/mag_enc_pkg.sv
// Shared types and constants for the magnetic encoder angle and speed core.
// Depends on nothing; compile before the interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package mag_enc_pkg;

  // Encoder word and turn geometry
  localparam int COUNT_BITS      = 12;
  localparam int COUNTS_PER_TURN = 1 << COUNT_BITS;
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

  // Pole-pair sectors of the electrical angle
  localparam int SECTOR_COUNTS = 372;
  localparam int HALF_SECTOR   = 186;
  localparam int SECTOR_NUM    = 11;
  localparam int SECTOR_LIMIT  = SECTOR_NUM * SECTOR_COUNTS;
  localparam int ANGLE_GAIN    = 'hB0;

  // Result field widths
  localparam int ANGLE_BITS = 16;
  localparam int SPEED_BITS = 16;
  localparam int SCALE_BITS = 16;

  // Register file
  localparam int                    CFG_DATA_BITS = 32;
  localparam int                    CFG_ADDR_BITS = 3;
  localparam logic                  REG_POSITION_OFFSET = 1'b0;
  localparam logic                  REG_SPEED_SCALE     = 1'b1;
  localparam logic [SCALE_BITS-1:0] SPEED_SCALE_RESET   = 16'd10000;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

endpackage

`default_nettype wire

FILE: design/mag_enc_in_if.sv
// Input channel of the encoder core: valid/ready plus one encoder item.
// Depends on mag_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mag_enc_in_if;
  import mag_enc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COUNT_BITS-1:0] raw_position;

  modport source (output valid, action, raw_position, input ready);
  modport sink   (input valid, action, raw_position, output ready);
endinterface

`default_nettype wire

FILE: design/mag_enc_out_if.sv
// Result channel of the encoder core: valid/ready plus angle and speed.
// Depends on mag_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mag_enc_out_if;
  import mag_enc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] electrical_angle;
  logic signed [SPEED_BITS-1:0] mech_speed;

  modport source (output valid, electrical_angle, mech_speed, input ready);
  modport sink   (input valid, electrical_angle, mech_speed, output ready);
endinterface

`default_nettype wire

FILE: design/magnetic_encoder_angle_speed_core.sv
// Magnetic encoder core: electrical angle and filtered mechanical speed.
// A result is registered in stage 1 and again in the output register.
// Throughput: one item per cycle unless the output stalls, ticks included.
// The stage register and the output register both advance while the output is
// free, so an item is taken while a finished result still waits.
// Reset (rst_n low, synchronous) clears state and valids; scale resets to 10000.
`timescale 1ns / 1ps
`default_nettype none

module magnetic_encoder_angle_speed_core #(
  parameter int FILTER_FRACTION_BITS = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  mag_enc_in_if.sink                            in_chan,
  mag_enc_out_if.source                         out_chan,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire [mag_enc_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire [mag_enc_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [mag_enc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                  pready
);
  import mag_enc_pkg::*;

  // Filter state width, its numerator width, and the reciprocal for divide by 5
  localparam int FW = COUNT_BITS + FILTER_FRACTION_BITS;
  localparam int NW = FW + 3;
  localparam logic [NW:0] DIV5_MUL = (NW+1)'(((64'd1 << (NW + 3)) + 64'd4) / 64'd5);
  localparam int SPW = FW + SCALE_BITS - 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Word addressed: the low two address bits are
  // ignored, so every write lands on one of the two registers.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] position_offset_r;
  logic [SCALE_BITS-1:0] speed_scale_r;
  logic                  cfg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_offset_r <= '0;
      speed_scale_r     <= SPEED_SCALE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POSITION_OFFSET: position_offset_r <= pwdata[COUNT_BITS-1:0];
        REG_SPEED_SCALE:     speed_scale_r     <= pwdata[SCALE_BITS-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POSITION_OFFSET: prdata = CFG_DATA_BITS'(position_offset_r);
      REG_SPEED_SCALE:     prdata = CFG_DATA_BITS'(speed_scale_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds the last sample's angle and last tick's filter state,
  // the output register the finished result. The output advances when empty or
  // taken; stage 1 when it is empty or the output advances.
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_tick_r;
  logic out_valid_r;
  logic out_adv;
  logic s1_free;
  logic in_fire;
  logic in_is_tick;

  assign out_adv       = !out_valid_r || out_chan.ready;
  assign s1_free       = !s1_valid_r || out_adv;
  assign in_chan.ready = s1_free;
  assign in_fire       = in_chan.valid && s1_free;
  assign in_is_tick    = (in_chan.action == ACT_TICK);

  // ---------------------------------------------------------------------------
  // Sample path: offset-corrected count, sector remainder, electrical angle.
  // ---------------------------------------------------------------------------
  logic        [COUNT_BITS-1:0] ang_pos;
  logic        [COUNT_BITS-1:0] sect_base;
  logic        [8:0]            sect_rem;
  logic                         at_limit;
  logic        [9:0]            ang_ofs;
  logic signed [ANGLE_BITS-1:0] ang_ofs_w;
  logic signed [ANGLE_BITS-1:0] angle_nxt;

  // Mod by the turn is the natural wrap of the 12-bit subtract
  assign ang_pos  = in_chan.raw_position - position_offset_r;
  assign at_limit = (ang_pos >= COUNT_BITS'(SECTOR_LIMIT));

  // Pick the highest sector start at or below the count; compares are parallel
  always_comb begin
    sect_base = '0;
    for (int k = 1; k <= SECTOR_NUM; k++) begin
      if (ang_pos >= COUNT_BITS'(k * SECTOR_COUNTS)) begin
        sect_base = COUNT_BITS'(k * SECTOR_COUNTS);
      end
    end
  end

  assign sect_rem = 9'(ang_pos - sect_base);

  // Past the last full sector the remainder is used without centering
  assign ang_ofs   = {1'b0, sect_rem} - (at_limit ? 10'd0 : 10'(HALF_SECTOR));
  assign ang_ofs_w = ANGLE_BITS'($signed(ang_ofs));
  assign angle_nxt = ang_ofs_w * $signed(ANGLE_BITS'(ANGLE_GAIN));

  // ---------------------------------------------------------------------------
  // Speed tick, first half: wrapped difference and filter update.
  // f_new = round((4*f + d*2^F) / 5), half away from zero, done on the
  // magnitude with a reciprocal multiply that is exact over the numerator range.
  // ---------------------------------------------------------------------------
  logic        [COUNT_BITS-1:0] latest_pos_r;
  logic        [COUNT_BITS-1:0] prev_pos_r;
  logic signed [FW-1:0]         filt_r;
  logic signed [ANGLE_BITS-1:0] angle_r;

  logic        [COUNT_BITS-1:0] diff_u;
  logic signed [COUNT_BITS:0]   pos_diff;
  logic signed [NW-1:0]         filt_n;
  logic signed [NW-1:0]         diff_n;
  logic signed [NW-1:0]         num;
  logic                         num_neg;
  logic        [NW-1:0]         num_mag;
  logic        [NW-1:0]         mag_rnd;
  logic        [2*NW:0]         prod5;
  logic        [FW-1:0]         quot5;
  logic signed [FW-1:0]         filt_nxt;

  // Exactly half a turn counts as forward
  assign diff_u   = latest_pos_r - prev_pos_r;
  assign pos_diff = (diff_u > COUNT_BITS'(HALF_TURN)) ? $signed({1'b1, diff_u})
                                                      : $signed({1'b0, diff_u});

  assign filt_n  = NW'(filt_r) <<< 2;
  assign diff_n  = NW'(pos_diff) <<< FILTER_FRACTION_BITS;
  assign num     = filt_n + diff_n;
  assign num_neg = num[NW-1];
  assign num_mag = num_neg ? NW'(-num) : NW'(num);
  assign mag_rnd = num_mag + NW'(2);
  assign prod5   = (2*NW+1)'(mag_rnd) * (2*NW+1)'(DIV5_MUL);
  assign quot5   = prod5[NW+3+FW-1:NW+3];

  // The filter settles one count short of the positive limit, so it never
  // leaves the state width and needs no clamp
  assign filt_nxt = num_neg ? -$signed(quot5) : $signed(quot5);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s1_tick_r    <= 1'b0;
      latest_pos_r <= '0;
      prev_pos_r   <= '0;
      filt_r       <= '0;
      angle_r      <= '0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_fire;
      end
      if (in_fire) begin
        s1_tick_r <= in_is_tick;
        if (in_is_tick) begin
          filt_r     <= filt_nxt;
          prev_pos_r <= latest_pos_r;
        end else begin
          latest_pos_r <= in_chan.raw_position;
          angle_r      <= angle_nxt;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Speed tick, second half: scale the registered filter value.
  // speed = round(f * scale / 2^(12+F)), half away from zero. The magnitude of
  // f stays below 2^(FW-1), so the quotient stays within 15 bits and fits
  // int16 without a clamp.
  // ---------------------------------------------------------------------------
  logic                         filt_neg;
  logic        [FW-1:0]         filt_abs;
  logic        [SPW-1:0]        spd_prod;
  logic        [SPW-1:0]        spd_rnd;
  logic        [SPW-FW-1:0]     spd_q;
  logic signed [SPEED_BITS-1:0] speed_nxt;
  logic signed [ANGLE_BITS-1:0] out_angle_r;
  logic signed [SPEED_BITS-1:0] out_speed_r;

  assign filt_neg  = filt_r[FW-1];
  assign filt_abs  = filt_neg ? FW'(-filt_r) : FW'(filt_r);
  assign spd_prod  = SPW'(filt_abs[FW-2:0]) * SPW'(speed_scale_r);
  assign spd_rnd   = spd_prod + (SPW'(1) << (FW - 1));
  assign spd_q     = spd_rnd[SPW-1:FW];
  assign speed_nxt = filt_neg ? -$signed(SPEED_BITS'(spd_q)) : $signed(SPEED_BITS'(spd_q));

  // The output speed doubles as the held speed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_angle_r <= '0;
      out_speed_r <= '0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        out_angle_r <= angle_r;
        if (s1_tick_r) begin
          out_speed_r <= speed_nxt;
        end
      end
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.electrical_angle = out_angle_r;
  assign out_chan.mech_speed       = out_speed_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ready_only_on_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a full pipeline");

  a_stage_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("stage 1 item lost on its way to the output");

  a_speed_held_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_adv && s1_valid_r && !s1_tick_r) |=> (out_speed_r == $past(out_speed_r)))
    else $error("speed changed on a sample item");

  a_filter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    filt_r != {1'b1, {(FW-1){1'b0}}})
    else $error("filter state reached the negative limit");

endmodule

`default_nettype wire

FILE: verif/tb_magnetic_encoder_angle_speed_core.sv
// Self-checking testbench for the magnetic encoder angle and speed core.
// Depends on mag_enc_pkg, mag_enc_in_if, mag_enc_out_if and the core itself.
`timescale 1ns / 1ps

module tb_magnetic_encoder_angle_speed_core;
  import mag_enc_pkg::*;

  localparam int FILT_FRAC   = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int HOLD_OFF    = 300;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle;
    logic signed [SPEED_BITS-1:0] speed;
  } encoder_result_t;

  // Angle/speed predictor plus the queue of results it still owes.
  class encoder_scoreboard;
    logic [COUNT_BITS-1:0] offset;
    logic [SCALE_BITS-1:0] scale;
    logic [COUNT_BITS-1:0] latest_pos;
    logic [COUNT_BITS-1:0] prev_pos;
    longint                filt;
    logic [ANGLE_BITS-1:0] angle_hold;
    logic [SPEED_BITS-1:0] speed_hold;
    encoder_result_t       owed_q[$];
    int                    errors;

    function new();
      offset     = '0;
      scale      = SPEED_SCALE_RESET;
      latest_pos = '0;
      prev_pos   = '0;
      filt       = 0;
      angle_hold = '0;
      speed_hold = '0;
      errors     = 0;
    endfunction

    static function longint div_round(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void set_register(logic idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_POSITION_OFFSET) offset = data[COUNT_BITS-1:0];
      else if (idx == REG_SPEED_SCALE) scale = data[SCALE_BITS-1:0];
    endfunction

    function void note_item(action_t act, logic [COUNT_BITS-1:0] raw);
      logic [COUNT_BITS-1:0] corr;
      logic [COUNT_BITS-1:0] delta;
      int                    a;
      int                    ang;
      int                    d;
      longint                lim;
      longint                f;
      longint                sp;
      encoder_result_t       res;
      if (act == ACT_SAMPLE) begin
        corr = raw - offset;
        a    = int'(corr);
        if (a >= SECTOR_LIMIT) ang = (a - SECTOR_LIMIT) * ANGLE_GAIN;
        else ang = ((a % SECTOR_COUNTS) - HALF_SECTOR) * ANGLE_GAIN;
        angle_hold = 16'(ang);
        latest_pos = raw;
      end else begin
        delta = latest_pos - prev_pos;
        d     = int'(delta);
        if (d > HALF_TURN) d -= COUNTS_PER_TURN;
        lim  = longint'(1) << (COUNT_BITS + FILT_FRAC - 1);
        f    = div_round(4 * filt + longint'(d) * (longint'(1) << FILT_FRAC), 5);
        f    = clamp(f, -lim, lim - 1);
        filt = f;
        sp   = div_round(f * longint'(scale), longint'(COUNTS_PER_TURN) << FILT_FRAC);
        sp   = clamp(sp, -32768, 32767);
        speed_hold = 16'(sp);
        prev_pos   = latest_pos;
      end
      res.angle = angle_hold;
      res.speed = speed_hold;
      owed_q.push_back(res);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic signed [ANGLE_BITS-1:0] ang,
                      logic signed [SPEED_BITS-1:0] spd);
      encoder_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result with no item pending, angle", int'(ang), 0);
      end else begin
        want = owed_q.pop_front();
        if (ang !== want.angle)
          report_mismatch("electrical_angle", int'(ang), int'(want.angle));
        if (spd !== want.speed)
          report_mismatch("mech_speed", int'(spd), int'(want.speed));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  mag_enc_in_if  in_if();
  mag_enc_out_if out_if();

  encoder_scoreboard sb;

  // Traffic shaping knobs, changed between phases by the main sequence.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;
  int cycle_count;

  // Simulated shaft: current position and per-sample step.
  logic [COUNT_BITS-1:0] shaft_pos;
  int                    shaft_step;

  magnetic_encoder_angle_speed_core #(
    .FILTER_FRACTION_BITS(FILT_FRAC)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Abort the run if the block stops making progress.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: lower ready at random, or hold it low for a counted stretch
  // when the main sequence asks for back-pressure.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_if.ready = 1'b0;
        hold_off_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every result accepted at a rising edge against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.electrical_angle, out_if.mech_speed);
  end

  // Offer one item; idle first at the current rate, then hold valid until the
  // block takes it. Return just after the following falling edge.
  task automatic send_item(action_t act, logic [COUNT_BITS-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid        = 1'b0;
      in_if.action       = 1'($urandom);
      in_if.raw_position = 12'($urandom);
      @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.action       = act;
    in_if.raw_position = raw;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(act, raw);
    @(negedge clk);
  endtask

  // Write one register through a setup and an access cycle; junk in the
  // upper data bits must be dropped by the block.
  task automatic cfg_write(logic idx, logic [CFG_DATA_BITS-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Stop offering, wait for every owed result, then let the pipeline settle.
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly a turning shaft sampled between speed ticks, with occasional new
  // speeds (half-turn steps among them) and stray readings as noise.
  task automatic send_random_item();
    int                    pick;
    action_t               act;
    logic [COUNT_BITS-1:0] raw;
    pick = $urandom_range(99);
    if (pick < 4) shaft_step = int'($urandom_range(COUNTS_PER_TURN - 1)) - (HALF_TURN - 1);
    else if (pick < 7) shaft_step = $urandom_range(1) ? HALF_TURN : 1 - HALF_TURN;
    else if (pick < 12) shaft_step = int'($urandom_range(64)) - 32;
    pick = $urandom_range(99);
    if (pick < 55) begin
      shaft_pos = shaft_pos + 12'(shaft_step);
      act       = ACT_SAMPLE;
      raw       = shaft_pos;
    end else if (pick < 90) begin
      act = ACT_TICK;
      raw = 12'($urandom);
    end else begin
      act = ACT_SAMPLE;
      raw = 12'($urandom);
    end
    send_item(act, raw);
  endtask

  initial begin
    int                    offset_pick[PHASES] = '{4095, 0, 2048, -1, 1, 4095, -1, 0};
    int                    scale_pick[PHASES]  = '{65535, 0, 10000, -1, 1, 65535, -1, 32768};
    logic [CFG_DATA_BITS-1:0] w;

    in_if.valid        = 1'b0;
    in_if.action       = ACT_SAMPLE;
    in_if.raw_position = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_off_left      = 0;
    shaft_pos          = '0;
    shaft_step         = 5;
    sb                 = new();

    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed items at the reset settings: a tick with no motion, the sector
    // edges of the angle, the top end of the last sector, an exact half-turn
    // step, the largest backward step and alternating bit patterns.
    send_item(ACT_TICK, 12'hFFF);
    send_item(ACT_SAMPLE, 12'd0);
    send_item(ACT_SAMPLE, 12'd4095);
    send_item(ACT_SAMPLE, 12'd4091);
    send_item(ACT_SAMPLE, 12'd4092);
    send_item(ACT_SAMPLE, 12'd371);
    send_item(ACT_SAMPLE, 12'd372);
    send_item(ACT_SAMPLE, 12'd186);
    send_item(ACT_TICK, 12'd0);
    send_item(ACT_SAMPLE, 12'd2234);
    send_item(ACT_TICK, 12'hAAA);
    send_item(ACT_SAMPLE, 12'd187);
    send_item(ACT_TICK, 12'h555);
    send_item(ACT_SAMPLE, 12'hAAA);
    send_item(ACT_TICK, 12'd0);
    send_item(ACT_SAMPLE, 12'h555);
    send_item(ACT_TICK, 12'hFFF);
    send_item(ACT_TICK, 12'd0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      // Reprogram both registers while idle, with junk above each field.
      w = $urandom();
      w[COUNT_BITS-1:0] = (offset_pick[p] < 0) ? 12'($urandom) : 12'(offset_pick[p]);
      cfg_write(REG_POSITION_OFFSET, w);
      w = $urandom();
      w[SCALE_BITS-1:0] = (scale_pick[p] < 0) ? 16'($urandom) : 16'(scale_pick[p]);
      cfg_write(REG_SPEED_SCALE, w);

      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      // Fill the pipeline against a long receiver hold-off once.
      if (p == 0) hold_off_left = HOLD_OFF;

      repeat (PHASE_ITEMS) send_random_item();
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
